// ===== rtl/core/gaussian_blur_3x3_stream_macros.svh =====
// assertion macros shared by the blur core
`ifndef GAUSSIAN_BLUR_3X3_STREAM_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet in reset
`define GB3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gb3_pkg.sv =====
// shared types and constants of the 3x3 blur core
`timescale 1ns / 1ps
package gb3_pkg;

  localparam int PIXEL_W        = 8;
  localparam int FRAME_WIDTH_W  = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int SUM_W          = 12;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int MIN_SIZE       = 3;

  localparam logic [FRAME_WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // position flags of one word, settled when it is taken
  typedef struct packed {
    logic emit;
    logic frame_end;
  } pos_t;

endpackage

// ===== rtl/core/gb3_line_mem.sv =====
// one line store: single write port, registered read port
`timescale 1ns / 1ps
module gb3_line_mem #(
  parameter int DEPTH = gb3_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [gb3_pkg::PIXEL_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [gb3_pkg::PIXEL_W-1:0] rdata_o
);
  import gb3_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gb3_ctrl.sv =====
// size registers and raster position counters
`timescale 1ns / 1ps
module gb3_ctrl #(
  parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           accept_i,
  output logic [CW-1:0]                  col_o,
  output gb3_pkg::pos_t                  pos_o
);
  import gb3_pkg::*;

  localparam int WW = (FRAME_WIDTH_W > CW + 1) ? FRAME_WIDTH_W : CW + 1;
  localparam int HW = (FRAME_HEIGHT_W > RW + 1) ? FRAME_HEIGHT_W : RW + 1;

  logic [FRAME_WIDTH_W-1:0]  width_q;
  logic [FRAME_HEIGHT_W-1:0] height_q;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [WW-1:0]             w_raw, w_eff, col_next;
  logic [HW-1:0]             h_raw, h_eff, row_next;
  logic                      row_end, frame_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
      endcase
    end
  end

  // clamp sizes into the supported range
  always_comb begin
    w_raw = WW'(width_q);
    h_raw = HW'(height_q);
    if (w_raw < WW'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HW'(MIN_SIZE)) begin
      h_eff = HW'(MIN_SIZE);
    end else if (h_raw > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  assign col_next  = WW'(col_q) + WW'(1);
  assign row_next  = HW'(row_q) + HW'(1);
  assign row_end   = (col_next >= w_eff);
  assign frame_end = row_end && (row_next >= h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_next[RW-1:0];
    end else begin
      col_d = col_next[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o           = col_q;
  assign pos_o.emit      = (row_q >= RW'(2)) && (col_q >= CW'(2));
  assign pos_o.frame_end = frame_end;

endmodule

// ===== rtl/core/gb3_window.sv =====
// held word, 3x3 window registers, kernel sum and result register
`timescale 1ns / 1ps
module gb3_window #(
  parameter int CW = $clog2(gb3_pkg::DEF_MAX_WIDTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [gb3_pkg::PIXEL_W-1:0] pixel_i,
  input  logic [CW-1:0]               col_i,
  input  gb3_pkg::pos_t               pos_i,
  input  logic [gb3_pkg::PIXEL_W-1:0] top_i,
  input  logic [gb3_pkg::PIXEL_W-1:0] mid_i,
  output logic                        busy_o,
  output logic                        held_o,
  output logic                        we_o,
  output logic [CW-1:0]               waddr_o,
  output logic [gb3_pkg::PIXEL_W-1:0] upper_wdata_o,
  output logic [gb3_pkg::PIXEL_W-1:0] middle_wdata_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gb3_pkg::PIXEL_W-1:0] blurred_pixel_o,
  output logic                        frame_done_o
);
  import gb3_pkg::*;

  logic               held_q;
  logic [PIXEL_W-1:0] pix_q;
  logic [CW-1:0]      col_q;
  pos_t               pos_q;
  logic [PIXEL_W-1:0] win_q [6];
  logic               out_valid_q;
  logic [PIXEL_W-1:0] blur_q;
  logic               done_q;
  logic               out_free, advance;
  logic [SUM_W-1:0]   sum;

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = held_q && (!pos_q.emit || out_free);
  assign busy_o   = held_q && !advance;
  assign held_o   = held_q;

  // read data of the line stores belongs to the held word
  assign we_o           = advance;
  assign waddr_o        = col_q;
  assign upper_wdata_o  = mid_i;
  assign middle_wdata_o = pix_q;

  // 1 2 1 / 2 4 2 / 1 2 1, columns c-2 (win 3..5), c-1 (win 0..2), c (top, mid, pixel)
  assign sum = SUM_W'(win_q[3]) + (SUM_W'(win_q[0]) << 1) + SUM_W'(top_i)
             + (SUM_W'(win_q[4]) << 1) + (SUM_W'(win_q[1]) << 2) + (SUM_W'(mid_i) << 1)
             + SUM_W'(win_q[5]) + (SUM_W'(win_q[2]) << 1) + SUM_W'(pix_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else if (accept_i) begin
      held_q <= 1'b1;
    end else if (advance) begin
      held_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pix_q <= pixel_i;
      col_q <= col_i;
      pos_q <= pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (advance) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top_i;
      win_q[1] <= mid_i;
      win_q[2] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && pos_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pos_q.emit) begin
      blur_q <= sum[SUM_W-1:SUM_W-PIXEL_W];
      done_q <= pos_q.frame_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_pixel_o = blur_q;
  assign frame_done_o    = done_q;

endmodule

// ===== rtl/core/gaussian_blur_3x3_stream.sv =====
// channel    | signals                                   | dir | handshake
// pixel in   | in_valid_i, in_stall_o, pixel_in_i        | in  | valid / stall
// result out | out_valid_o, out_stall_i, blurred_pixel_o,| out | valid / stall
//            | frame_done_o                              |     |
// config     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in  | valid / ready
//            | cfg_data_i                                |     |
//
// one pixel word per cycle while in_stall_o is low; a result passes the held word and result registers
// the line stores are read when a pixel is taken and written when the held word advances
// reset clears counters and window, sizes go to 640 x 480, line stores are not cleared
// in_stall_o rises only while a finished result waits and the held pixel has one too
`timescale 1ns / 1ps
module gaussian_blur_3x3_stream #(
  parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gb3_pkg::PIXEL_W-1:0]    pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gb3_pkg::PIXEL_W-1:0]    blurred_pixel_o,
  output logic                           frame_done_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gb3_pkg::*;

  `include "gaussian_blur_3x3_stream_macros.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic               accept, busy, held, we, cfg_ready;
  logic [CW-1:0]      rd_col, wr_col;
  pos_t               pos;
  logic [PIXEL_W-1:0] top, mid, upper_wdata, middle_wdata;

  assign accept      = in_valid_i && !busy;
  assign in_stall_o  = busy;
  assign cfg_ready_o = cfg_ready;

  gb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .col_o       (rd_col),
    .pos_o       (pos)
  );

  gb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_col),
    .wdata_i (upper_wdata),
    .re_i    (accept),
    .raddr_i (rd_col),
    .rdata_o (top)
  );

  gb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_col),
    .wdata_i (middle_wdata),
    .re_i    (accept),
    .raddr_i (rd_col),
    .rdata_o (mid)
  );

  gb3_window #(
    .CW (CW)
  ) u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .pixel_i         (pixel_in_i),
    .col_i           (rd_col),
    .pos_i           (pos),
    .top_i           (top),
    .mid_i           (mid),
    .busy_o          (busy),
    .held_o          (held),
    .we_o            (we),
    .waddr_o         (wr_col),
    .upper_wdata_o   (upper_wdata),
    .middle_wdata_o  (middle_wdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .blurred_pixel_o (blurred_pixel_o),
    .frame_done_o    (frame_done_o)
  );

  // a line store is never read and written at the same column in one cycle
  `GB3_ASSERT_NOW(a_no_rw_clash, accept && we, rd_col != wr_col, "line store read/write clash")

  // input stalls only behind a blocked result
  `GB3_ASSERT_NOW(a_stall_cause, in_stall_o, held && out_valid_o && out_stall_i, "spurious stall")

  // a taken word is held in the next cycle
  `GB3_ASSERT_NEXT(a_accept_held, accept, held, "taken word lost")

endmodule
